// ----- rtl/itoa_pkg.sv -----
// Package for the integer to ASCII formatter: request and result types,
// command codes, character constants and the decimal digit count helper.
// No dependencies.
package itoa_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int COUNT_W         = 32;

    localparam logic [2:0] CMD_SDEC = 3'd0;
    localparam logic [2:0] CMD_UDEC = 3'd1;
    localparam logic [2:0] CMD_HEXL = 3'd2;
    localparam logic [2:0] CMD_HEXU = 3'd3;
    localparam logic [2:0] CMD_PTR  = 3'd4;

    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_UA    = 8'h41;
    localparam logic [7:0] CHR_LA    = 8'h61;
    localparam logic [7:0] CHR_MINUS = 8'h2d;
    localparam logic [7:0] CHR_X     = 8'h78;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         character;
        logic               last_char;
        logic [COUNT_W-1:0] running_count;
    } t_out_item;

    // Decimal digits needed for an unsigned value of the given width
    // (log10(2) ~ 0.302, one digit of margin).
    function automatic int f_dec_digits(int width);
        return (width * 302) / 1000 + 1;
    endfunction

endpackage

// ----- rtl/integer_to_ascii_formatter_unit.sv -----
// Integer to ASCII formatter, top level: request decode, prefix and digit
// emission, saturating character count. Depends on itoa_pkg, itoa_dabble.
//
// Usage: one request (cmd, value) enters on the input channel when
// i_in_valid is high and o_in_stall is low. The block then sends the text of
// the value one character per result on the output channel, most
// significant digit first, with last_char set on the final character.
// Requests with an unused cmd code are taken and dropped with no output.
// Decimal modes run a bit-serial BCD converter, hex modes load the digits
// directly. A pass that drops leading zeros follows, and each character
// goes through the output register. o_in_stall is high from acceptance
// until the last character is loaded into the output register; one request
// is worked on at a time. When i_out_stall is high while the output is
// valid, the output register holds and emission waits. Reset clears the
// state machine, the output valid and the count.
module integer_to_ascii_formatter_unit #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  itoa_pkg::t_in_item i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output itoa_pkg::t_out_item o_out_data
);
    import itoa_pkg::*;

    localparam int BCD_DIGITS = f_dec_digits(VALUE_WIDTH);
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int LEFT_W     = $clog2(BCD_DIGITS + 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE, S_CONV, S_SKIP, S_PRE, S_DIG
    } t_state;

    typedef enum logic [1:0] {
        PRE_NONE, PRE_MINUS, PRE_ZERO, PRE_X
    } t_pre;

    t_state              r_state;
    t_pre                r_pre;
    logic                r_upper;
    logic [BCD_W-1:0]    r_dig;
    logic [LEFT_W-1:0]   r_left;
    logic [COUNT_W-1:0]  r_total;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                   w_in_acc;
    logic                   w_emit_ok;
    logic                   w_load;
    logic [VALUE_WIDTH-1:0] w_val;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic                   w_neg;
    logic                   w_dab_start;
    logic [VALUE_WIDTH-1:0] w_dab_value;
    logic                   w_done;
    logic [BCD_W-1:0]       w_bcd;
    logic [COUNT_W-1:0]     w_total_inc;
    logic [3:0]             w_top;

    function automatic logic [7:0] f_digit_char(logic [3:0] d, logic upper);
        if (d < 4'd10) begin
            return CHR_ZERO + {4'd0, d};
        end
        return (upper ? CHR_UA : CHR_LA) + {4'd0, d} - 8'd10;
    endfunction

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_emit_ok   = !r_out_valid || !i_out_stall;
    assign w_load      = w_emit_ok && (r_state == S_PRE || r_state == S_DIG);
    assign w_val       = i_in_data.value[VALUE_WIDTH-1:0];
    assign w_neg       = w_val[VALUE_WIDTH-1];
    assign w_mag       = ~w_val + VALUE_WIDTH'(1);
    assign w_dab_start = w_in_acc && (i_in_data.cmd == CMD_SDEC || i_in_data.cmd == CMD_UDEC);
    assign w_dab_value = (i_in_data.cmd == CMD_SDEC && w_neg) ? w_mag : w_val;
    assign w_total_inc = (r_total == COUNT_MAX) ? r_total : r_total + COUNT_W'(1);
    assign w_top       = r_dig[BCD_W-1 -: 4];

    itoa_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .BCD_W       (BCD_W)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dab_start),
        .i_value (w_dab_value),
        .o_done  (w_done),
        .o_bcd   (w_bcd)
    );

    // output register valid: reloaded whenever the register may move
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit_ok) begin
            r_out_valid <= w_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pre       <= PRE_NONE;
            r_total     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_left  <= LEFT_W'(BCD_DIGITS);
                        r_upper <= (i_in_data.cmd == CMD_HEXU);
                        r_dig   <= BCD_W'(w_val);
                        unique case (i_in_data.cmd)
                            CMD_SDEC: begin
                                r_pre   <= w_neg ? PRE_MINUS : PRE_NONE;
                                r_state <= S_CONV;
                            end
                            CMD_UDEC: begin
                                r_pre   <= PRE_NONE;
                                r_state <= S_CONV;
                            end
                            CMD_HEXL, CMD_HEXU: begin
                                r_pre   <= PRE_NONE;
                                r_state <= S_SKIP;
                            end
                            CMD_PTR: begin
                                r_pre   <= PRE_ZERO;
                                r_state <= S_SKIP;
                            end
                            default: begin
                                r_state <= S_IDLE;  // unused code: dropped
                            end
                        endcase
                    end
                end
                S_CONV: begin
                    if (w_done) begin
                        r_dig   <= w_bcd;
                        r_state <= S_SKIP;
                    end
                end
                S_SKIP: begin
                    if (w_top == 4'd0 && r_left > LEFT_W'(1)) begin
                        r_dig  <= {r_dig[BCD_W-5:0], 4'd0};
                        r_left <= r_left - LEFT_W'(1);
                    end else begin
                        r_state <= (r_pre != PRE_NONE) ? S_PRE : S_DIG;
                    end
                end
                S_PRE: begin
                    if (w_emit_ok) begin
                        r_out.last_char         <= 1'b0;
                        r_out.running_count     <= w_total_inc;
                        r_total                 <= w_total_inc;
                        unique case (r_pre)
                            PRE_MINUS: begin
                                r_out.character <= CHR_MINUS;
                                r_pre           <= PRE_NONE;
                                r_state         <= S_DIG;
                            end
                            PRE_ZERO: begin
                                r_out.character <= CHR_ZERO;
                                r_pre           <= PRE_X;
                            end
                            PRE_X: begin
                                r_out.character <= CHR_X;
                                r_pre           <= PRE_NONE;
                                r_state         <= S_DIG;
                            end
                            default: begin
                                r_out.character <= CHR_ZERO;
                                r_state         <= S_DIG;
                            end
                        endcase
                    end
                end
                S_DIG: begin
                    if (w_emit_ok) begin
                        r_out.character     <= f_digit_char(w_top, r_upper);
                        r_out.last_char     <= (r_left == LEFT_W'(1));
                        r_out.running_count <= w_total_inc;
                        r_total             <= w_total_inc;
                        r_dig               <= {r_dig[BCD_W-5:0], 4'd0};
                        r_left              <= r_left - LEFT_W'(1);
                        if (r_left == LEFT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // digit count never runs out while digits are still owed
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SKIP || r_state == S_PRE || r_state == S_DIG) |-> r_left != '0)
        else $error("digit counter empty in emit path");

    // converter finishes only while the top level waits for it
    a_done_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_state == S_CONV)
        else $error("BCD converter done outside conversion");

    // final digit loads a last-marked result and frees the input side
    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIG && w_emit_ok && r_left == LEFT_W'(1))
        |=> (r_state == S_IDLE && o_out_valid && o_out_data.last_char))
        else $error("last digit not marked");

    // character count never goes backward
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_total >= $past(r_total))
        else $error("character count decreased");

endmodule

// ----- rtl/itoa_dabble.sv -----
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Depends on itoa_pkg.
module itoa_dabble #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF,
    parameter int BCD_W       = 4 * itoa_pkg::f_dec_digits(VALUE_WIDTH)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_done,
    output logic [BCD_W-1:0]       o_bcd
);
    import itoa_pkg::*;

    localparam int NDIG  = BCD_W / 4;
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] r_bin;
    logic [BCD_W-1:0]       r_bcd;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_done;
    logic [BCD_W-1:0]       w_adj;

    always_comb begin
        for (int j = 0; j < NDIG; j++) begin
            w_adj[4*j +: 4] = (r_bcd[4*j +: 4] >= 4'd5) ? r_bcd[4*j +: 4] + 4'd3
                                                        : r_bcd[4*j +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_bin  <= i_value;
            r_bcd  <= '0;
            r_cnt  <= CNT_W'(VALUE_WIDTH);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_bcd  <= {w_adj[BCD_W-2:0], r_bin[VALUE_WIDTH-1]};
            r_bin  <= {r_bin[VALUE_WIDTH-2:0], 1'b0};
            r_cnt  <= r_cnt - CNT_W'(1);
            r_done <= (r_cnt == CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule
